// File: hdl/oprd_pkg.sv
// ----------------------------------------------------------------------------
// oprd_pkg
// Shared constants for the optical pulse rate detector: register indexes,
// register reset values, window defaults and rate formula constants.
// ----------------------------------------------------------------------------
package oprd_pkg;

   // register indexes on the csr port
   localparam logic [7:0] CSR_AMBIENT_LIMIT   = 8'd0;
   localparam logic [7:0] CSR_SIGNAL_FLOOR    = 8'd1;
   localparam logic [7:0] CSR_EDGE_MARGIN     = 8'd2;
   localparam logic [7:0] CSR_SETTLE_SAMPLES  = 8'd3;
   localparam logic [7:0] CSR_PULSES_PER_RATE = 8'd4;
   localparam logic [7:0] CSR_TICK_RATE_HZ    = 8'd5;
   localparam logic [7:0] CSR_RATE_ALARM_HIGH = 8'd6;
   localparam logic [7:0] CSR_RATE_ALARM_LOW  = 8'd7;

   // register reset values
   localparam logic [15:0] AMBIENT_LIMIT_RST   = 16'd350;
   localparam logic [15:0] SIGNAL_FLOOR_RST    = 16'd1000;
   localparam logic [11:0] EDGE_MARGIN_RST     = 12'd10;
   localparam logic [15:0] SETTLE_SAMPLES_RST  = 16'd8;
   localparam logic [7:0]  PULSES_PER_RATE_RST = 8'd4;
   localparam logic [15:0] TICK_RATE_HZ_RST    = 16'd1000;
   localparam logic [15:0] RATE_ALARM_HIGH_RST = 16'd160;
   localparam logic [15:0] RATE_ALARM_LOW_RST  = 16'd30;

   // window depth defaults
   localparam int SAMPLE_WINDOW_DEF = 16;
   localparam int RATE_WINDOW_DEF   = 8;

   // rate formula: pulses * 60000 / (ticks * tick_rate)
   localparam logic [15:0] RATE_SCALE = 16'd60000;
   localparam logic [15:0] RATE_SAT   = 16'hFFFF;
   localparam logic [15:0] SETTLE_MAX = 16'hFFFF;

endpackage

// File: hdl/optical_pulse_rate_detector.sv
// ----------------------------------------------------------------------------
// optical_pulse_rate_detector
// Presence check, sliding-window mean of the pulse channel, hysteresis pulse
// edge detector, rate computation and a sliding-window mean of the rates.
// ----------------------------------------------------------------------------
// handshake: one sample at a time; a stalled result beat holds off the next
//   sample
// reset: synchronous, clears control, counters and sums and loads the
//   configuration registers with their reset values; payload, divider data
//   and result registers and the window memories are not cleared
module optical_pulse_rate_detector #(
   parameter int SAMPLE_WINDOW = oprd_pkg::SAMPLE_WINDOW_DEF,
   parameter int RATE_WINDOW   = oprd_pkg::RATE_WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_ambient_sample,
   input  logic [15:0] req_signal_sample,
   input  logic [31:0] req_elapsed_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_present,
   output logic        rsp_measuring,
   output logic        rsp_pulse_high,
   output logic        rsp_rate_updated,
   output logic [15:0] rsp_rate_mean,
   output logic        rsp_rate_alarm,
   output logic        rsp_timer_restart,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import oprd_pkg::*;

   localparam int SFILL_W = $clog2(SAMPLE_WINDOW + 1);
   localparam int SIDX_W  = $clog2(SAMPLE_WINDOW);
   localparam int SSUM_W  = 16 + SFILL_W;
   localparam int RFILL_W = $clog2(RATE_WINDOW + 1);
   localparam int RIDX_W  = $clog2(RATE_WINDOW);
   localparam int RSUM_W  = 16 + RFILL_W;
   localparam int DEN_W   = 48;
   localparam int NUM_W   = (SSUM_W > 24) ? SSUM_W : 24;
   localparam int CNT_W   = $clog2(NUM_W + 1);

   // reciprocal constants for the full-window means
   localparam int SREC_W = SSUM_W + 1;
   localparam int SREC_K = SSUM_W + $clog2(SAMPLE_WINDOW);
   localparam logic [SREC_W-1:0] SREC_M = SREC_W'(((64'd1 << SREC_K)
      + 64'(SAMPLE_WINDOW) - 64'd1) / 64'(SAMPLE_WINDOW));
   localparam int RREC_W = RSUM_W + 1;
   localparam int RREC_K = RSUM_W + $clog2(RATE_WINDOW);
   localparam logic [RREC_W-1:0] RREC_M = RREC_W'(((64'd1 << RREC_K)
      + 64'(RATE_WINDOW) - 64'd1) / 64'(RATE_WINDOW));

   localparam logic [SFILL_W-1:0] SW_FULL = SFILL_W'(SAMPLE_WINDOW);
   localparam logic [SIDX_W-1:0]  SW_LAST = SIDX_W'(SAMPLE_WINDOW - 1);
   localparam logic [RFILL_W-1:0] RW_FULL = RFILL_W'(RATE_WINDOW);
   localparam logic [RIDX_W-1:0]  RW_LAST = RIDX_W'(RATE_WINDOW - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_SRD   = 4'd2;
   localparam logic [3:0] S_SDIV  = 4'd3;
   localparam logic [3:0] S_EDGE  = 4'd4;
   localparam logic [3:0] S_RMUL  = 4'd5;
   localparam logic [3:0] S_RDIV  = 4'd6;
   localparam logic [3:0] S_RWIN  = 4'd7;
   localparam logic [3:0] S_RRD   = 4'd8;
   localparam logic [3:0] S_ADIV  = 4'd9;
   localparam logic [3:0] S_RFIN  = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;
   localparam logic [3:0] S_SMUL  = 4'd12;
   localparam logic [3:0] S_AMUL  = 4'd13;

   // configuration registers
   logic [15:0] amb_lim_ff, sig_floor_ff, settle_lim_ff, tick_hz_ff, alm_hi_ff, alm_lo_ff;
   logic [11:0] margin_ff;
   logic [7:0]  ppr_ff;

   // block state
   logic [3:0]         state_ff, state_in;
   logic [15:0]        amb_ff, amb_in, sig_ff, sig_in;
   logic [31:0]        ticks_ff, ticks_in;
   logic [SFILL_W-1:0] sfill_ff, sfill_in;
   logic [SIDX_W-1:0]  shead_ff, shead_in;
   logic [SSUM_W-1:0]  ssum_ff, ssum_in;
   logic [15:0]        smean_ff, smean_in;
   logic               filling_ff, filling_in;
   logic [RFILL_W-1:0] rfill_ff, rfill_in;
   logic [RIDX_W-1:0]  rhead_ff, rhead_in;
   logic [RSUM_W-1:0]  rsum_ff, rsum_in;
   logic [15:0]        ravg_ff, ravg_in;
   logic [15:0]        rate_ff, rate_in;
   logic [7:0]         tally_ff, tally_in;
   logic [15:0]        settle_ff, settle_in;
   logic               pulse_ff, pulse_in;
   logic               meas_ff, meas_in;
   logic               present_ff, present_in;
   logic               upd_ff, upd_in;
   logic               alarm_ff, alarm_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [23:0]        num_ff, num_in;

   // result register
   logic        rv_ff, rv_in;
   logic        o_present_ff, o_meas_ff, o_pulse_ff, o_upd_ff, o_alarm_ff, o_restart_ff;
   logic [15:0] o_mean_ff;
   logic        out_load;

   // window memories
   logic [15:0]       smem [SAMPLE_WINDOW];
   logic [15:0]       rmem [RATE_WINDOW];
   logic [15:0]       srd_ff, rrd_ff;
   logic              swe, sre, rwe, rre;
   logic [SIDX_W-1:0] swa, sra;
   logic [RIDX_W-1:0] rwa, rra;
   logic [15:0]       swd, rwd;

   // shared divider
   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [NUM_W-1:0] dq_ff;
   logic [DEN_W-1:0] drem_ff, dden_ff;
   logic [CNT_W-1:0] dcnt_ff;
   logic [DEN_W:0]   drem_sh;
   logic             dbit;
   logic             div_done;

   // full-window mean products
   logic [SSUM_W+SREC_W-1:0] sprod;
   logic [RSUM_W+RREC_W-1:0] rprod;

   // edge detection terms
   logic        present_c, settled, rising, falling;
   logic [16:0] mean_hi, sig_hi;
   logic [7:0]  tally_inc;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign present_c = !((amb_ff > amb_lim_ff) || (sig_ff < sig_floor_ff));
   assign mean_hi   = {1'b0, smean_ff} + {5'd0, margin_ff};
   assign sig_hi    = {1'b0, sig_ff} + {5'd0, margin_ff};
   assign settled   = settle_ff > settle_lim_ff;
   assign rising    = (mean_hi < {1'b0, sig_ff}) && !pulse_ff && settled;
   assign falling   = ({1'b0, smean_ff} > sig_hi) && pulse_ff && settled;
   assign tally_inc = tally_ff + 8'd1;
   assign div_done  = (dcnt_ff == '0);
   assign out_load  = (state_ff == S_OUT) && (!rv_ff || rsp_ready);

   // sum times reciprocal of the window size
   assign sprod = {{SREC_W{1'b0}}, ssum_ff} * {{SSUM_W{1'b0}}, SREC_M};
   assign rprod = {{RREC_W{1'b0}}, rsum_ff} * {{RSUM_W{1'b0}}, RREC_M};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         amb_lim_ff    <= AMBIENT_LIMIT_RST;
         sig_floor_ff  <= SIGNAL_FLOOR_RST;
         margin_ff     <= EDGE_MARGIN_RST;
         settle_lim_ff <= SETTLE_SAMPLES_RST;
         ppr_ff        <= PULSES_PER_RATE_RST;
         tick_hz_ff    <= TICK_RATE_HZ_RST;
         alm_hi_ff     <= RATE_ALARM_HIGH_RST;
         alm_lo_ff     <= RATE_ALARM_LOW_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_AMBIENT_LIMIT:   amb_lim_ff    <= csr_data;
            CSR_SIGNAL_FLOOR:    sig_floor_ff  <= csr_data;
            CSR_EDGE_MARGIN:     margin_ff     <= csr_data[11:0];
            CSR_SETTLE_SAMPLES:  settle_lim_ff <= csr_data;
            CSR_PULSES_PER_RATE: ppr_ff        <= csr_data[7:0];
            CSR_TICK_RATE_HZ:    tick_hz_ff    <= csr_data;
            CSR_RATE_ALARM_HIGH: alm_hi_ff     <= csr_data;
            CSR_RATE_ALARM_LOW:  alm_lo_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // radix-2 restoring divider step
   assign drem_sh = {drem_ff, dq_ff[NUM_W-1]};
   assign dbit    = (drem_sh >= {1'b0, dden_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (div_start) begin
         dcnt_ff <= CNT_W'(NUM_W);
      end else if (!div_done) begin
         dcnt_ff <= dcnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dq_ff   <= div_num;
         drem_ff <= '0;
         dden_ff <= div_den;
      end else if (!div_done) begin
         drem_ff <= dbit ? DEN_W'(drem_sh - {1'b0, dden_ff}) : drem_sh[DEN_W-1:0];
         dq_ff   <= {dq_ff[NUM_W-2:0], dbit};
      end
   end

   // sample window memory
   always_ff @(posedge clock) begin
      if (swe) begin
         smem[swa] <= swd;
      end
      if (sre) begin
         srd_ff <= smem[sra];
      end
   end

   // rate window memory
   always_ff @(posedge clock) begin
      if (rwe) begin
         rmem[rwa] <= rwd;
      end
      if (rre) begin
         rrd_ff <= rmem[rra];
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      amb_in     = amb_ff;
      sig_in     = sig_ff;
      ticks_in   = ticks_ff;
      sfill_in   = sfill_ff;
      shead_in   = shead_ff;
      ssum_in    = ssum_ff;
      smean_in   = smean_ff;
      filling_in = filling_ff;
      rfill_in   = rfill_ff;
      rhead_in   = rhead_ff;
      rsum_in    = rsum_ff;
      ravg_in    = ravg_ff;
      rate_in    = rate_ff;
      tally_in   = tally_ff;
      settle_in  = settle_ff;
      pulse_in   = pulse_ff;
      meas_in    = meas_ff;
      present_in = present_ff;
      upd_in     = upd_ff;
      alarm_in   = alarm_ff;
      den_in     = den_ff;
      num_in     = num_ff;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      swe = 1'b0; sre = 1'b0; swa = shead_ff; sra = shead_ff; swd = sig_ff;
      rwe = 1'b0; rre = 1'b0; rwa = rhead_ff; rra = rhead_ff; rwd = rate_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               amb_in   = req_ambient_sample;
               sig_in   = req_signal_sample;
               ticks_in = req_elapsed_ticks;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            present_in = present_c;
            upd_in     = 1'b0;
            alarm_in   = 1'b0;
            if (!present_c) begin
               // no hand: drop the measurement, keep the settle count
               tally_in = '0;
               smean_in = '0;
               ravg_in  = '0;
               sfill_in = '0;
               rfill_in = '0;
               shead_in = '0;
               rhead_in = '0;
               ssum_in  = '0;
               rsum_in  = '0;
               meas_in  = 1'b0;
               pulse_in = 1'b0;
               state_in = S_OUT;
            end else begin
               meas_in = 1'b1;
               if (sfill_ff < SW_FULL) begin
                  // window filling: store at fill position
                  swe        = 1'b1;
                  swa        = SIDX_W'(sfill_ff);
                  ssum_in    = ssum_ff + SSUM_W'(sig_ff);
                  sfill_in   = sfill_ff + SFILL_W'(1);
                  filling_in = 1'b1;
                  if (sfill_ff == '0) begin
                     smean_in = (smean_ff != '0) ?
                                16'(({1'b0, smean_ff} + {1'b0, sig_ff}) >> 1) : sig_ff;
                     state_in = S_OUT;
                  end else begin
                     div_start = 1'b1;
                     div_num   = NUM_W'(ssum_ff);
                     div_den   = DEN_W'(sfill_ff);
                     state_in  = S_SDIV;
                  end
               end else begin
                  // window full: fetch the oldest entry
                  sre        = 1'b1;
                  filling_in = 1'b0;
                  state_in   = S_SRD;
               end
            end
         end
         S_SRD: begin
            swe       = 1'b1;
            ssum_in   = ssum_ff - SSUM_W'(srd_ff) + SSUM_W'(sig_ff);
            shead_in  = (shead_ff == SW_LAST) ? '0 : shead_ff + SIDX_W'(1);
            state_in  = S_SMUL;
         end
         S_SMUL: begin
            smean_in = sprod[SREC_K +: 16];
            state_in = S_EDGE;
         end
         S_SDIV: begin
            if (div_done) begin
               smean_in = dq_ff[15:0];
               state_in = filling_ff ? S_OUT : S_EDGE;
            end
         end
         S_EDGE: begin
            // hysteresis edge test against the fresh mean
            if (rising) begin
               pulse_in = 1'b1;
               tally_in = tally_inc;
               if (tally_inc == ppr_ff) begin
                  den_in   = {16'd0, ticks_ff} * {32'd0, tick_hz_ff};
                  num_in   = {16'd0, ppr_ff} * {8'd0, RATE_SCALE};
                  state_in = S_RMUL;
               end else begin
                  settle_in = (settle_ff < SETTLE_MAX) ? settle_ff + 16'd1 : settle_ff;
                  state_in  = S_OUT;
               end
            end else if (falling) begin
               pulse_in  = 1'b0;
               settle_in = 16'd1;
               state_in  = S_OUT;
            end else begin
               settle_in = (settle_ff < SETTLE_MAX) ? settle_ff + 16'd1 : settle_ff;
               state_in  = S_OUT;
            end
         end
         S_RMUL: begin
            if (den_ff == '0) begin
               rate_in  = RATE_SAT;
               state_in = S_RWIN;
            end else begin
               div_start = 1'b1;
               div_num   = NUM_W'(num_ff);
               div_den   = den_ff;
               state_in  = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_done) begin
               rate_in  = (|dq_ff[NUM_W-1:16]) ? RATE_SAT : dq_ff[15:0];
               state_in = S_RWIN;
            end
         end
         S_RWIN: begin
            if (rfill_ff < RW_FULL) begin
               rwe     = 1'b1;
               rwa     = RIDX_W'(rfill_ff);
               rsum_in = rsum_ff + RSUM_W'(rate_ff);
               if (rfill_ff == '0) begin
                  ravg_in  = (ravg_ff != '0) ?
                             16'(({1'b0, ravg_ff} + {1'b0, rate_ff}) >> 1) : rate_ff;
                  state_in = S_RFIN;
               end else begin
                  div_start = 1'b1;
                  div_num   = NUM_W'(rsum_ff);
                  div_den   = DEN_W'(rfill_ff);
                  state_in  = S_ADIV;
               end
            end else begin
               rre      = 1'b1;
               state_in = S_RRD;
            end
         end
         S_RRD: begin
            rwe       = 1'b1;
            rsum_in   = rsum_ff - RSUM_W'(rrd_ff) + RSUM_W'(rate_ff);
            rhead_in  = (rhead_ff == RW_LAST) ? '0 : rhead_ff + RIDX_W'(1);
            state_in  = S_AMUL;
         end
         S_AMUL: begin
            ravg_in  = rprod[RREC_K +: 16];
            state_in = S_RFIN;
         end
         S_ADIV: begin
            if (div_done) begin
               ravg_in  = dq_ff[15:0];
               state_in = S_RFIN;
            end
         end
         S_RFIN: begin
            tally_in  = '0;
            settle_in = 16'd1;
            rfill_in  = (rfill_ff < RW_FULL) ? rfill_ff + RFILL_W'(1) : rfill_ff;
            upd_in    = 1'b1;
            alarm_in  = (ravg_ff > alm_hi_ff) || (ravg_ff < alm_lo_ff);
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         sfill_ff   <= '0;
         shead_ff   <= '0;
         ssum_ff    <= '0;
         smean_ff   <= '0;
         filling_ff <= 1'b0;
         rfill_ff   <= '0;
         rhead_ff   <= '0;
         rsum_ff    <= '0;
         ravg_ff    <= '0;
         tally_ff   <= '0;
         settle_ff  <= '0;
         pulse_ff   <= 1'b0;
         meas_ff    <= 1'b0;
         present_ff <= 1'b0;
         upd_ff     <= 1'b0;
         alarm_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sfill_ff   <= sfill_in;
         shead_ff   <= shead_in;
         ssum_ff    <= ssum_in;
         smean_ff   <= smean_in;
         filling_ff <= filling_in;
         rfill_ff   <= rfill_in;
         rhead_ff   <= rhead_in;
         rsum_ff    <= rsum_in;
         ravg_ff    <= ravg_in;
         tally_ff   <= tally_in;
         settle_ff  <= settle_in;
         pulse_ff   <= pulse_in;
         meas_ff    <= meas_in;
         present_ff <= present_in;
         upd_ff     <= upd_in;
         alarm_ff   <= alarm_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      amb_ff   <= amb_in;
      sig_ff   <= sig_in;
      ticks_ff <= ticks_in;
      rate_ff  <= rate_in;
      den_ff   <= den_in;
      num_ff   <= num_in;
   end

   // result beat register
   always_comb begin
      rv_in = rv_ff;
      if (out_load) begin
         rv_in = 1'b1;
      end else if (rsp_ready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_present_ff <= present_ff;
         o_meas_ff    <= meas_ff;
         o_pulse_ff   <= pulse_ff;
         o_upd_ff     <= upd_ff;
         o_mean_ff    <= ravg_ff;
         o_alarm_ff   <= alarm_ff;
         o_restart_ff <= upd_ff || !meas_ff;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_present       = o_present_ff;
   assign rsp_measuring     = o_meas_ff;
   assign rsp_pulse_high    = o_pulse_ff;
   assign rsp_rate_updated  = o_upd_ff;
   assign rsp_rate_mean     = o_mean_ff;
   assign rsp_rate_alarm    = o_alarm_ff;
   assign rsp_timer_restart = o_restart_ff;

   // checks
   a_alarm_needs_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rate_alarm |-> rsp_rate_updated)
      else $error("alarm without rate update");

   a_absent_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> !rsp_measuring && rsp_timer_restart && !rsp_pulse_high)
      else $error("absent sample left measurement running");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while busy");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (sfill_ff <= SW_FULL) && (rfill_ff <= RW_FULL))
      else $error("window fill count overran");

endmodule
